FILE: rtl/resource_lock_table_macros.svh
// Assertion macros for the resource lock table.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RESOURCE_LOCK_TABLE_MACROS_SVH
`define RESOURCE_LOCK_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RLT_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("resource lock table check failed");
// Next-cycle implication.
`define RLT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("resource lock table check failed");
`else
`define RLT_ASSERT_IMP(label, cond, prop)
`define RLT_ASSERT_NEXT(label, cond, prop)
`endif
`endif

FILE: rtl/rlt_pkg.sv
`timescale 1ns / 1ps
package rlt_pkg;

  localparam int ResCount     = 1024;
  localparam int ResBits      = 10;
  localparam int MissionBits  = 16;
  localparam int TimeBits     = 32;
  localparam int MaxList      = 32;
  localparam int ListIdxBits  = 5;
  localparam int CntBits      = 6;
  localparam int SlotsPerRes  = 8;
  localparam int SlotIdxBits  = 3;
  localparam int SlotAddrBits = ResBits + SlotIdxBits;
  localparam int SlotTotal    = ResCount * SlotsPerRes;

  // Operation codes
  localparam logic [2:0] KIND_RSV   = 3'd0;
  localparam logic [2:0] KIND_WIN   = 3'd1;
  localparam logic [2:0] KIND_REL   = 3'd2;
  localparam logic [2:0] KIND_BLK   = 3'd3;
  localparam logic [2:0] KIND_UNBLK = 3'd4;
  localparam logic [2:0] KIND_QRY   = 3'd5;

  // Status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_EMPTY    = 4'd1;
  localparam logic [3:0] ST_LOCKED   = 4'd2;
  localparam logic [3:0] ST_BAD_INT  = 4'd3;
  localparam logic [3:0] ST_STATIC   = 4'd4;
  localparam logic [3:0] ST_CLASH    = 4'd5;
  localparam logic [3:0] ST_FULL     = 4'd6;
  localparam logic [3:0] ST_HELD     = 4'd7;
  localparam logic [3:0] ST_NOT_LOCK = 4'd8;
  localparam logic [3:0] ST_BY_MISS  = 4'd9;
  localparam logic [3:0] ST_OVERFLOW = 4'd10;

  typedef struct packed {
    logic [2:0]             kind;
    logic [MissionBits-1:0] mission;
    logic [ResBits-1:0]     resource;
    logic                   last_item;
    logic [TimeBits-1:0]    window_start;
    logic [TimeBits-1:0]    window_end;
    logic [15:0]            block_reason;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         status;
    logic [ResBits-1:0] conflict_resource;
    logic [15:0]        conflict_owner;
    logic               conflict_is_block;
    logic               is_locked;
    logic               released_any;
    logic [5:0]         reserved_count;
  } result_t;

  typedef struct packed {
    logic                   held;
    logic                   blocked;
    logic [MissionBits-1:0] owner;
  } lock_t;

  typedef struct packed {
    logic                   valid;
    logic [MissionBits-1:0] mission;
    logic [TimeBits-1:0]    wstart;
    logic [TimeBits-1:0]    wend;
  } slot_t;

  typedef struct packed {
    logic bad_interval;
    logic foreign;
    logic mine;
    logic slot_free;
    logic slot_mine;
    logic slot_clash;
  } cmp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RSV_RD,
    S_RSV_CHK,
    S_RSV_WR,
    S_WIN_LRD,
    S_WIN_LCHK,
    S_WIN_SRD,
    S_WIN_SCHK,
    S_WIN_WR,
    S_REL,
    S_REL_LAST,
    S_ONE_RD,
    S_ONE_CHK,
    S_DONE
  } state_t;

endpackage

FILE: rtl/rlt_cmp.sv
`timescale 1ns / 1ps
// Shared compare unit: checks the item's window, and one lock entry and one slot against the item.
module rlt_cmp (
  input  rlt_pkg::item_t item,
  input  rlt_pkg::lock_t lock,
  input  rlt_pkg::slot_t slot,
  output rlt_pkg::cmp_t  cmp
);
  import rlt_pkg::*;

  // Interval and ownership checks
  assign cmp.bad_interval = item.window_start >= item.window_end;
  assign cmp.foreign      = lock.held && (lock.blocked || lock.owner != item.mission);
  assign cmp.mine         = lock.held && !lock.blocked && lock.owner == item.mission;

  // Slot checks, half-open overlap
  assign cmp.slot_free  = !slot.valid;
  assign cmp.slot_mine  = slot.valid && slot.mission == item.mission;
  assign cmp.slot_clash = slot.valid && slot.mission != item.mission
                          && slot.wstart < item.window_end
                          && item.window_start < slot.wend;

endmodule

FILE: rtl/resource_lock_table.sv
`timescale 1ns / 1ps
// A reserve list end checks the lock of each buffered item, then writes them all if none
// is foreign; a window reserve checks the interval, the lock and each slot of the resource;
// release scans the slot memory one slot a cycle; block/unblock/query check one lock entry.
// Reserve items that are not last are buffered without leaving idle. One item is in work at
// a time, around one compare unit and one read and one write port per memory. Reset is
// synchronous active-low; a clearing pass empties both memories, in_stall high throughout.
module resource_lock_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rlt_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rlt_pkg::result_t out_data
);
  import rlt_pkg::*;

  `include "resource_lock_table_macros.svh"

  state_t state_r, state_nxt;

  item_t   item_r;
  result_t res_r;
  result_t res_init;
  result_t out_data_r;
  logic    out_valid_r;

  logic [SlotAddrBits-1:0] clr_r;
  logic [SlotAddrBits-1:0] scan_r;
  logic [SlotAddrBits-1:0] scan_d_r;
  logic                    scan_v_r;
  logic                    any_r;

  logic [ResBits-1:0]     pend_r [MaxList];
  logic [CntBits-1:0]     pend_cnt_r;
  logic                   pend_ovf_r;
  logic [ListIdxBits-1:0] idx_r;

  logic [SlotIdxBits-1:0] slot_idx_r;
  logic [SlotIdxBits-1:0] free_idx_r;
  logic                   free_found_r;

  lock_t lk_mem [ResCount];
  lock_t lk_rd_r;
  logic [ResBits-1:0] lk_raddr, lk_waddr;
  logic  lk_we;
  lock_t lk_wdata;

  slot_t sl_mem [SlotTotal];
  slot_t sl_rd_r;
  logic [SlotAddrBits-1:0] sl_raddr, sl_waddr;
  logic  sl_we;
  slot_t sl_wdata;

  cmp_t cmp;

  logic accept, list_full, list_last, slot_last, done_go, rel_lock_hit, rel_slot_hit;

  rlt_cmp u_cmp (
    .item (item_r),
    .lock (lk_rd_r),
    .slot (sl_rd_r),
    .cmp  (cmp)
  );

  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign list_full = pend_cnt_r == CntBits'(MaxList);
  assign list_last = ({1'b0, idx_r} + CntBits'(1)) == pend_cnt_r;
  assign slot_last = slot_idx_r == SlotIdxBits'(SlotsPerRes - 1);
  assign done_go   = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign rel_slot_hit = scan_v_r && cmp.slot_mine;
  assign rel_lock_hit = scan_v_r && scan_d_r[SlotIdxBits-1:0] == '0 && cmp.mine;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Seed the result; a list end refused up front gets its status here
  always_comb begin
    res_init = '0;
    if (in_data.kind == KIND_RSV && in_data.last_item) begin
      if (in_data.mission == '0) res_init.status = ST_EMPTY;
      else if (pend_ovf_r || list_full) res_init.status = ST_OVERFLOW;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_RSV: begin
              if (!in_data.last_item) state_nxt = S_IDLE;
              else if (in_data.mission == '0) state_nxt = S_DONE;
              else if (pend_ovf_r || list_full) state_nxt = S_DONE;
              else state_nxt = S_RSV_RD;
            end
            KIND_WIN: state_nxt = S_WIN_LRD;
            KIND_REL: state_nxt = S_REL;
            KIND_BLK, KIND_UNBLK, KIND_QRY: state_nxt = S_ONE_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RSV_RD:  state_nxt = S_RSV_CHK;
      S_RSV_CHK: begin
        if (cmp.foreign) state_nxt = S_DONE;
        else if (list_last) state_nxt = S_RSV_WR;
        else state_nxt = S_RSV_RD;
      end
      S_RSV_WR: begin
        if (list_last) state_nxt = S_DONE;
      end
      S_WIN_LRD:  state_nxt = cmp.bad_interval ? S_DONE : S_WIN_LCHK;
      S_WIN_LCHK: state_nxt = cmp.foreign ? S_DONE : S_WIN_SRD;
      S_WIN_SRD:  state_nxt = S_WIN_SCHK;
      S_WIN_SCHK: begin
        if (cmp.slot_clash) state_nxt = S_DONE;
        else if (slot_last) state_nxt = (free_found_r || cmp.slot_free) ? S_WIN_WR : S_DONE;
        else state_nxt = S_WIN_SRD;
      end
      S_WIN_WR: state_nxt = S_DONE;
      S_REL: begin
        if (scan_r == '1) state_nxt = S_REL_LAST;
      end
      S_REL_LAST: state_nxt = S_DONE;
      S_ONE_RD:   state_nxt = S_ONE_CHK;
      S_ONE_CHK:  state_nxt = S_DONE;
      S_DONE: begin
        if (done_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    lk_raddr = item_r.resource;
    lk_we    = 1'b0;
    lk_waddr = item_r.resource;
    lk_wdata = '0;
    sl_raddr = {item_r.resource, slot_idx_r};
    sl_we    = 1'b0;
    sl_waddr = {item_r.resource, free_idx_r};
    sl_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r[ResBits-1:0];
        sl_we    = 1'b1;
        sl_waddr = clr_r;
      end
      S_RSV_RD: lk_raddr = pend_r[idx_r];
      S_RSV_WR: begin
        lk_we    = 1'b1;
        lk_waddr = pend_r[idx_r];
        lk_wdata = '{held: 1'b1, blocked: 1'b0, owner: item_r.mission};
      end
      S_WIN_WR: begin
        sl_we    = 1'b1;
        sl_wdata = '{valid: 1'b1, mission: item_r.mission,
                     wstart: item_r.window_start, wend: item_r.window_end};
      end
      S_REL, S_REL_LAST: begin
        sl_raddr = scan_r;
        lk_raddr = scan_r[SlotAddrBits-1:SlotIdxBits];
        sl_waddr = scan_d_r;
        lk_waddr = scan_d_r[SlotAddrBits-1:SlotIdxBits];
        sl_we    = rel_slot_hit;
        sl_wdata = '{valid: 1'b0, mission: sl_rd_r.mission,
                     wstart: sl_rd_r.wstart, wend: sl_rd_r.wend};
        lk_we    = rel_lock_hit;
        lk_wdata = '{held: 1'b0, blocked: lk_rd_r.blocked, owner: lk_rd_r.owner};
      end
      S_ONE_CHK: begin
        if (item_r.kind == KIND_BLK && !lk_rd_r.held) begin
          lk_we    = 1'b1;
          lk_wdata = '{held: 1'b1, blocked: 1'b1, owner: item_r.block_reason};
        end else if (item_r.kind == KIND_UNBLK && lk_rd_r.held && lk_rd_r.blocked) begin
          lk_we    = 1'b1;
          lk_wdata = '{held: 1'b0, blocked: 1'b0, owner: lk_rd_r.owner};
        end
      end
      default: ;
    endcase
  end

  // Lock and slot memories, registered reads
  always_ff @(posedge clk) begin
    lk_rd_r <= lk_mem[lk_raddr];
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    sl_rd_r <= sl_mem[sl_raddr];
    if (sl_we) sl_mem[sl_waddr] <= sl_wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_cnt_r  <= '0;
      pend_ovf_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + SlotAddrBits'(1);
      // buffer reserve items
      if (accept && in_data.kind == KIND_RSV) begin
        if (list_full) pend_ovf_r <= 1'b1;
        else pend_cnt_r <= pend_cnt_r + CntBits'(1);
      end
      // drop the list after its end is reported
      if (done_go && item_r.kind == KIND_RSV) begin
        pend_cnt_r <= '0;
        pend_ovf_r <= 1'b0;
      end
      if (accept) scan_v_r <= 1'b0;
      else if (state_r == S_REL) scan_v_r <= 1'b1;
      if (done_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_RSV && !list_full) begin
      pend_r[pend_cnt_r[ListIdxBits-1:0]] <= in_data.resource;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_r       <= in_data;
          res_r        <= res_init;
          idx_r        <= '0;
          slot_idx_r   <= '0;
          free_idx_r   <= '0;
          free_found_r <= 1'b0;
          scan_r       <= '0;
          any_r        <= 1'b0;
        end
      end
      S_RSV_CHK: begin
        if (cmp.foreign) begin
          res_r.status            <= ST_LOCKED;
          res_r.conflict_resource <= pend_r[idx_r];
          res_r.conflict_owner    <= lk_rd_r.owner;
          res_r.conflict_is_block <= lk_rd_r.blocked;
        end else if (list_last) begin
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + ListIdxBits'(1);
        end
      end
      S_RSV_WR: begin
        idx_r <= idx_r + ListIdxBits'(1);
        if (list_last) begin
          res_r.ok             <= 1'b1;
          res_r.reserved_count <= pend_cnt_r;
        end
      end
      S_WIN_LRD: begin
        if (cmp.bad_interval) res_r.status <= ST_BAD_INT;
      end
      S_WIN_LCHK: begin
        if (cmp.foreign) begin
          res_r.status            <= ST_STATIC;
          res_r.conflict_resource <= item_r.resource;
          res_r.conflict_owner    <= lk_rd_r.owner;
          res_r.conflict_is_block <= lk_rd_r.blocked;
        end
      end
      S_WIN_SCHK: begin
        if (cmp.slot_clash) begin
          res_r.status            <= ST_CLASH;
          res_r.conflict_resource <= item_r.resource;
          res_r.conflict_owner    <= sl_rd_r.mission;
        end else begin
          if (cmp.slot_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= slot_idx_r;
          end
          if (slot_last && !free_found_r && !cmp.slot_free) res_r.status <= ST_FULL;
          slot_idx_r <= slot_idx_r + SlotIdxBits'(1);
        end
      end
      S_WIN_WR: res_r.ok <= 1'b1;
      S_REL: begin
        scan_r   <= scan_r + SlotAddrBits'(1);
        scan_d_r <= scan_r;
        if (rel_slot_hit || rel_lock_hit) any_r <= 1'b1;
      end
      S_REL_LAST: begin
        res_r.ok           <= 1'b1;
        res_r.released_any <= any_r || rel_slot_hit || rel_lock_hit;
      end
      S_ONE_CHK: begin
        case (item_r.kind)
          KIND_BLK: begin
            if (lk_rd_r.held) begin
              res_r.status            <= ST_HELD;
              res_r.conflict_resource <= item_r.resource;
              res_r.conflict_owner    <= lk_rd_r.owner;
              res_r.conflict_is_block <= lk_rd_r.blocked;
            end else begin
              res_r.ok <= 1'b1;
            end
          end
          KIND_UNBLK: begin
            if (!lk_rd_r.held) begin
              res_r.status <= ST_NOT_LOCK;
            end else if (!lk_rd_r.blocked) begin
              res_r.status            <= ST_BY_MISS;
              res_r.conflict_resource <= item_r.resource;
              res_r.conflict_owner    <= lk_rd_r.owner;
              res_r.conflict_is_block <= lk_rd_r.blocked;
            end else begin
              res_r.ok <= 1'b1;
            end
          end
          default: begin
            res_r.ok <= 1'b1;
            if (lk_rd_r.held) begin
              res_r.is_locked         <= 1'b1;
              res_r.conflict_resource <= item_r.resource;
              res_r.conflict_owner    <= lk_rd_r.owner;
              res_r.conflict_is_block <= lk_rd_r.blocked;
            end
          end
        endcase
      end
      S_DONE: begin
        if (done_go) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

  // Checks
  `RLT_ASSERT_IMP(a_cnt_bound, 1'b1, pend_cnt_r <= CntBits'(MaxList))
  `RLT_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r)
  `RLT_ASSERT_NEXT(a_list_dropped, done_go && item_r.kind == KIND_RSV, pend_cnt_r == '0 && !pend_ovf_r)
  `RLT_ASSERT_IMP(a_count_ok, out_valid_r && out_data_r.reserved_count != '0, out_data_r.ok)
  `RLT_ASSERT_IMP(a_ok_status, out_valid_r && out_data_r.ok, out_data_r.status == ST_OK)

endmodule
